/* rtl/spq_pkg.sv */
// Shared types and codes for the stable priority queue.
package spq_pkg;

    localparam int IdW   = 8;
    localparam int PrioW = 8;
    localparam int StW   = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [StW-1:0] ST_INSERTED = 2'd0;
    localparam logic [StW-1:0] ST_FULL     = 2'd1;
    localparam logic [StW-1:0] ST_POPPED   = 2'd2;
    localparam logic [StW-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [IdW-1:0]   id;
        logic [PrioW-1:0] prio;
    } spq_entry_t;

    typedef struct packed {
        logic             ins;
        logic             pop;
        logic [IdW-1:0]   id;
        logic [PrioW-1:0] prio;
    } spq_ctrl_t;

endpackage

/* rtl/spq_cell.sv */
// One queue slot: holds an entry, shifts toward the tail on insert, toward the head on pop.
module spq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::spq_ctrl_t ctrl,
    input  spq_pkg::spq_entry_t left,
    input  logic               left_after,
    input  spq_pkg::spq_entry_t right,
    output spq_pkg::spq_entry_t cur,
    output logic               after
);
    import spq_pkg::*;

    logic             valid_reg, valid_next;
    logic [IdW-1:0]   id_reg, id_next;
    logic [PrioW-1:0] prio_reg, prio_next;

    // new entry belongs behind this slot
    assign after = valid_reg && (prio_reg >= ctrl.prio);

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        prio_next  = prio_reg;
        if (ctrl.pop)
        begin
            valid_next = right.valid;
            id_next    = right.id;
            prio_next  = right.prio;
        end
        else if (ctrl.ins && !after)
        begin
            if (left_after)
            begin
                valid_next = 1'b1;
                id_next    = ctrl.id;
                prio_next  = ctrl.prio;
            end
            else
            begin
                valid_next = left.valid;
                id_next    = left.id;
                prio_next  = left.prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

    assign cur = '{valid: valid_reg, id: id_reg, prio: prio_reg};

endmodule

/* rtl/stable_priority_queue_top.sv */
// Top level of the stable priority queue: cell chain, count and result register.
//
//  channel | handshake          | beat fields
//  --------+--------------------+----------------------------------------------
//  in      | in_valid, in_stall | operation, task_id, task_prio
//  out     | out_valid,out_stall| status, out_id, out_priority, occupancy
//
// One beat per cycle while in_stall is low: every cell compares and shifts in the same
// cycle, so the cell chain sets the rate at one item per clock.
// Result appears in the cycle after the input beat, held in the output register.
// in_stall is high while a result waits and out_stall is high.
// Reset clears all cell valid bits and the count; queue starts empty.
module stable_priority_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             operation,
    input  logic [spq_pkg::IdW-1:0]          task_id,
    input  logic [spq_pkg::PrioW-1:0]        task_prio,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [spq_pkg::StW-1:0]          status,
    output logic [spq_pkg::IdW-1:0]          out_id,
    output logic [spq_pkg::PrioW-1:0]        out_priority,
    output logic [$clog2(DEPTH+1)-1:0]       occupancy
);
    import spq_pkg::*;

    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    spq_entry_t cells [DEPTH];
    logic       afters [DEPTH];
    spq_ctrl_t  ctrl;

    logic            accept;
    logic            full;
    logic            empty;
    logic [CntW-1:0] count_reg, count_next;
    logic            out_valid_reg, out_valid_next;
    logic [StW-1:0]  status_reg, status_next;
    logic [IdW-1:0]  out_id_reg, out_id_next;
    logic [PrioW-1:0] out_prio_reg, out_prio_next;
    logic [CntW-1:0] occ_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == FullCnt);
    assign empty    = (count_reg == '0);

    assign ctrl.ins  = accept && (operation == OP_INSERT) && !full;
    assign ctrl.pop  = accept && (operation == OP_POP) && !empty;
    assign ctrl.id   = task_id;
    assign ctrl.prio = task_prio;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            spq_entry_t left_e;
            spq_entry_t right_e;
            logic       left_a;
            if (g == 0)
            begin : g_head
                assign left_e = '0;
                assign left_a = 1'b1;
            end
            else
            begin : g_mid
                assign left_e = cells[g-1];
                assign left_a = afters[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_tail
                assign right_e = '0;
            end
            else
            begin : g_body
                assign right_e = cells[g+1];
            end
            spq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .left       (left_e),
                .left_after (left_a),
                .right      (right_e),
                .cur        (cells[g]),
                .after      (afters[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next    = count_reg;
        status_next   = status_reg;
        out_id_next   = out_id_reg;
        out_prio_next = out_prio_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_id_next    = '0;
            out_prio_next  = '0;
            if (operation == OP_INSERT)
            begin
                if (full)
                    status_next = ST_FULL;
                else
                begin
                    status_next = ST_INSERTED;
                    count_next  = count_reg + CntW'(1);
                end
            end
            else
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                begin
                    status_next   = ST_POPPED;
                    out_id_next   = cells[0].id;
                    out_prio_next = cells[0].prio;
                    count_next    = count_reg - CntW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        out_id_reg   <= out_id_next;
        out_prio_reg <= out_prio_next;
        if (accept)
            occ_reg <= count_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_id       = out_id_reg;
    assign out_priority = out_prio_reg;
    assign occupancy    = occ_reg;

endmodule

/* rtl/spq_checker.sv */
// Port-level checks for the stable priority queue, bound to the top level.
module spq_checker #(
    parameter int DEPTH = 16
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [spq_pkg::StW-1:0]     status,
    input logic [spq_pkg::IdW-1:0]     out_id,
    input logic [spq_pkg::PrioW-1:0]   out_priority,
    input logic [$clog2(DEPTH+1)-1:0]  occupancy
);
    import spq_pkg::*;

    localparam int CntW = $clog2(DEPTH + 1);

    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted beat gave no result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(out_id)
            && $stable(out_priority) && $stable(occupancy)))
        else $error("stalled result changed");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_EMPTY) |-> (occupancy == '0))
        else $error("empty status with nonzero occupancy");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (occupancy == CntW'(DEPTH)))
        else $error("full status below depth");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_POPPED) |-> (out_id == '0 && out_priority == '0))
        else $error("nonzero task on non-pop result");

endmodule

bind stable_priority_queue_top spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_id       (out_id),
    .out_priority (out_priority),
    .occupancy    (occupancy)
);
